// File: sv/sotv_pkg.sv
`timescale 1ns / 1ps

package sotv_pkg;

  // Offset, dictionary, status and kind widths
  localparam int unsigned OffsetWidth = 32;
  localparam int unsigned DictWidth   = 19;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned KindWidth   = 2;

  // An overflow string marker takes exactly this many dictionary bytes
  localparam int unsigned MarkerBytes  = 12;
  // Dictionary size register is clamped to this bound
  localparam int unsigned MaxDictBytes = 262144;

  // Packed stream widths (data widths are whole bytes)
  localparam int unsigned InDataWidth  = 64;
  localparam int unsigned InUserWidth  = 1;
  localparam int unsigned OutDataWidth = 48;
  localparam int unsigned OutUserWidth = KindWidth;

  // Status codes, first failing check wins
  localparam logic [StatusWidth-1:0] StOk         = 3'd0;
  localparam logic [StatusWidth-1:0] StMin        = 3'd1;
  localparam logic [StatusWidth-1:0] StBeyond     = 3'd2;
  localparam logic [StatusWidth-1:0] StDecreasing = 3'd3;
  localparam logic [StatusWidth-1:0] StMarker     = 3'd4;

  // Entry kinds
  localparam logic [KindWidth-1:0] KindInline   = 2'd0;
  localparam logic [KindWidth-1:0] KindNull     = 2'd1;
  localparam logic [KindWidth-1:0] KindOverflow = 2'd2;

  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [KindWidth-1:0]   entry_kind;
    logic [DictWidth-1:0]   str_len;
    logic [DictWidth-1:0]   dict_position;
    logic                   range_ok;
  } result_t;

endpackage

// File: sv/string_offset_table_validator.sv
`timescale 1ns / 1ps

// Checks a stream of signed 32-bit cumulative string offsets against the
// dictionary size and the previous entry, and gives one result per entry:
// status, entry kind, string length, dictionary start position and a sticky
// range-valid flag. An entry that arrives with start_range set restarts the
// range and takes prior_offset as its predecessor. Each entry passes an
// input register and a result register; the negate, compare and subtract
// on the previous offset sit in the single logic stage between them, so
// one entry is taken every cycle as long as results are taken. Write the
// dictionary size only while no entry is in flight.
module string_offset_table_validator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write: dictionary size in bytes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sotv_pkg::DictWidth-1:0]      cfg_data_i,
  // entries in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] entry_offset, [63:32] prior_offset
  input  logic [sotv_pkg::InDataWidth-1:0]    s_axis_tdata,
  // [0] start_range
  input  logic [sotv_pkg::InUserWidth-1:0]    s_axis_tuser,
  // results out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [2:0] status, [21:3] string length, [40:22] dict_position,
  // [41] range_ok, [47:42] zero
  output logic [sotv_pkg::OutDataWidth-1:0]   m_axis_tdata,
  // [1:0] entry_kind
  output logic [sotv_pkg::OutUserWidth-1:0]   m_axis_tuser
);
  import sotv_pkg::*;

  localparam logic [OffsetWidth-1:0] MaxDict   = OffsetWidth'(MaxDictBytes);
  localparam logic [OffsetWidth-1:0] MarkerLen = OffsetWidth'(MarkerBytes);
  localparam logic [OffsetWidth-1:0] MinOffset = {1'b1, {(OffsetWidth-1){1'b0}}};

  // configuration
  logic [DictWidth-1:0] dict_size_q;

  // input register
  logic                   in_valid_q;
  logic [OffsetWidth-1:0] cur_q, prior_q;
  logic                   start_q;

  // state
  logic [OffsetWidth-1:0] prev_offset_q;
  logic                   range_valid_q;

  // result register
  logic    out_valid_q;
  result_t res_q, res_d;

  logic advance, in_take;

  logic [OffsetWidth-1:0] prev_raw, cabs, pabs, diff, dsize32;
  logic [DictWidth-1:0]   dsize;
  logic                   cur_neg;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    prev_raw = start_q ? prior_q : prev_offset_q;
    cur_neg  = cur_q[OffsetWidth-1];
    cabs     = cur_neg ? (~cur_q + 1'b1) : cur_q;
    pabs     = prev_raw[OffsetWidth-1] ? (~prev_raw + 1'b1) : prev_raw;
    diff     = cabs - pabs;
    // clamp an oversized register to the bound
    if (OffsetWidth'(dict_size_q) > MaxDict) begin
      dsize = MaxDict[DictWidth-1:0];
    end else begin
      dsize = dict_size_q;
    end
    dsize32 = OffsetWidth'(dsize);

    res_d = '0;
    if (prev_raw == MinOffset) begin
      res_d.status = StMin;
    end else if (pabs > dsize32) begin
      res_d.status = StBeyond;
    end else if (cur_q == MinOffset) begin
      res_d.status = StMin;
    end else if (cabs > dsize32) begin
      res_d.status = StBeyond;
    end else if (cabs < pabs) begin
      res_d.status = StDecreasing;
    end else if (cur_neg && (diff == '0) && (cur_q != prev_raw)) begin
      res_d.status = StMarker;
    end else if (cur_neg && (diff != '0) && (diff != MarkerLen)) begin
      res_d.status = StMarker;
    end else begin
      res_d.status = StOk;
    end

    if (res_d.status == StOk) begin
      res_d.str_len       = diff[DictWidth-1:0];
      res_d.dict_position = dsize - cabs[DictWidth-1:0];
      if (cur_neg) begin
        res_d.entry_kind = (diff == '0) ? KindNull : KindOverflow;
      end else begin
        res_d.entry_kind = KindInline;
      end
    end
    res_d.range_ok = (start_q || range_valid_q) && (res_d.status == StOk);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dict_size_q   <= '0;
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      prev_offset_q <= '0;
      range_valid_q <= 1'b1;
    end else begin
      if (cfg_valid_i) begin
        dict_size_q <= cfg_data_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q   <= 1'b1;
        prev_offset_q <= cur_q;
        range_valid_q <= res_d.range_ok;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cur_q   <= s_axis_tdata[OffsetWidth-1:0];
      prior_q <= s_axis_tdata[2*OffsetWidth-1:OffsetWidth];
      start_q <= s_axis_tuser[0];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {
    (OutDataWidth - StatusWidth - 2*DictWidth - 1)'(0),
    res_q.range_ok, res_q.dict_position, res_q.str_len, res_q.status
  };
  assign m_axis_tuser  = res_q.entry_kind;

  // a failed entry carries no kind, length or position
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status != StOk) |->
      (res_q.entry_kind == KindInline && res_q.str_len == '0 &&
       res_q.dict_position == '0))
    else $error("failed entry has nonzero payload");

  a_range_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.range_ok) |-> (res_q.status == StOk))
    else $error("range_ok set on a failed entry");

  a_null_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.entry_kind == KindNull) |-> (res_q.str_len == '0))
    else $error("null entry with nonzero length");

  a_marker_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.entry_kind == KindOverflow) |->
      (res_q.str_len == MarkerLen[DictWidth-1:0]))
    else $error("overflow marker with wrong length");

  a_prev_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (prev_offset_q == $past(cur_q) &&
                 range_valid_q == $past(res_d.range_ok)))
    else $error("state not taken from the transferred entry");

endmodule
